// File: src/tpsd_pkg.sv
// tpsd_pkg: shared types and constants of the tga pixel stream decoder
// used by tpsd_cfg_if, the front, the queue, the back and the top level
package tpsd_pkg;

  // pixel format codes held in the format register
  localparam logic [2:0] FMT_RAW16 = 3'd0;
  localparam logic [2:0] FMT_RAW24 = 3'd1;
  localparam logic [2:0] FMT_RAW32 = 3'd2;
  localparam logic [2:0] FMT_RLE24 = 3'd3;
  localparam logic [2:0] FMT_RLE32 = 3'd4;

  // configuration register indexes
  localparam int unsigned CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_FORMAT = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PIXEL_TOTAL  = 2'd1;
  localparam int unsigned CFG_DATA_W = 32;

  // reset values of the registers
  localparam logic [2:0]  FORMAT_RESET = FMT_RAW24;
  localparam logic [31:0] TOTAL_RESET  = 32'd1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

  // one assembled pixel or run, front to back
  typedef struct packed {
    logic [31:0] word;          // bytes of the pixel, first byte at bit 0
    logic        fmt16;         // word holds a 5-5-5 pixel
    logic [7:0]  repeat_count;
    logic        last_pixel;
  } tpsd_entry_t;

endpackage

// File: src/tpsd_byte_if.sv
// tpsd_byte_if: input byte channel of the decoder
// depends on nothing
interface tpsd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// File: src/tpsd_pixel_if.sv
// tpsd_pixel_if: output pixel channel of the decoder
// depends on nothing
interface tpsd_pixel_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       last_pixel;

  modport source (output valid, output red, output green, output blue, output alpha,
                  output repeat_count, output last_pixel, input ready);
  modport sink (input valid, input red, input green, input blue, input alpha,
                input repeat_count, input last_pixel, output ready);
endinterface

// File: src/tpsd_cfg_if.sv
// tpsd_cfg_if: register write channel of the decoder
// depends on tpsd_pkg for the index and data widths
interface tpsd_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [tpsd_pkg::CFG_INDEX_W-1:0]    index;
  logic [tpsd_pkg::CFG_DATA_W-1:0]     data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// File: src/tpsd_front.sv
// tpsd_front: takes bytes, parses rle headers, assembles pixels, counts pixels
// depends on tpsd_pkg, tpsd_byte_if and tpsd_cfg_if
module tpsd_front (
  input  logic                  clk,
  input  logic                  rst,
  tpsd_byte_if.sink             byte_in,
  tpsd_cfg_if.sink              cfg,
  input  logic                  queue_full,
  output logic                  push,
  output tpsd_pkg::tpsd_entry_t push_entry
);

  logic [2:0]  pixel_format;
  logic [31:0] pixel_total;
  logic [1:0]  byte_phase;
  logic [23:0] pending_bytes;
  logic        expect_header;
  logic        packet_is_run;
  logic [7:0]  packet_left;
  logic [31:0] pixels_left;

  logic        accept;
  logic        cfg_write;
  logic        rle;
  logic [1:0]  last_phase;
  logic [7:0]  b;
  logic [31:0] pixels_eff;
  logic [7:0]  hdr_count;
  logic [7:0]  hdr_count_clip;
  logic [31:0] word;
  logic [7:0]  rep_raw;
  logic [7:0]  rep;
  logic [31:0] pixels_after;
  logic        is_last;
  logic        header_byte;
  logic        pixel_done;
  logic [7:0]  packet_left_next;

  assign byte_in.ready = !queue_full;
  assign cfg.ready     = 1'b1;
  assign accept        = byte_in.valid && byte_in.ready;
  assign cfg_write     = cfg.valid && cfg.ready &&
                         (cfg.index == tpsd_pkg::CFG_PIXEL_FORMAT ||
                          cfg.index == tpsd_pkg::CFG_PIXEL_TOTAL);
  assign b             = byte_in.data_byte;

  // format decode: rle flag and index of the final byte of a pixel
  always_comb begin
    rle        = 1'b0;
    last_phase = 2'd2;
    unique case (pixel_format) inside
      tpsd_pkg::FMT_RAW16: begin
        last_phase = 2'd1;
      end
      tpsd_pkg::FMT_RAW32: begin
        last_phase = 2'd3;
      end
      tpsd_pkg::FMT_RLE24: begin
        rle = 1'b1;
      end
      tpsd_pkg::FMT_RLE32: begin
        rle        = 1'b1;
        last_phase = 2'd3;
      end
      default: begin
        last_phase = 2'd2;
      end
    endcase
  end

  // pixels left in the image; at image start the total, a total of zero counting as one
  always_comb begin
    if (pixels_left != 32'd0) begin
      pixels_eff = pixels_left;
    end else if (pixel_total == 32'd0) begin
      pixels_eff = 32'd1;
    end else begin
      pixels_eff = pixel_total;
    end
  end

  // packet header: raw packet of value+1, run of value-127, clipped to the image
  assign hdr_count      = b[7] ? (b - 8'd127) : (b + 8'd1);
  assign hdr_count_clip = (pixels_eff < {24'd0, hdr_count}) ? pixels_eff[7:0] : hdr_count;

  assign header_byte = rle && expect_header;
  assign pixel_done  = !header_byte && (byte_phase == last_phase);

  // full pixel word from the pending bytes and this byte
  always_comb begin
    case (byte_phase)
      2'd0:    word = {24'd0, b};
      2'd1:    word = {16'd0, b, pending_bytes[7:0]};
      2'd2:    word = {8'd0, b, pending_bytes[15:0]};
      default: word = {b, pending_bytes};
    endcase
  end

  // repeat count and remaining pixels
  assign rep_raw          = (rle && packet_is_run) ? packet_left : 8'd1;
  assign rep              = (pixels_eff < {24'd0, rep_raw}) ? pixels_eff[7:0] : rep_raw;
  assign pixels_after     = pixels_eff - {24'd0, rep};
  assign is_last          = (pixels_after == 32'd0);
  assign packet_left_next = packet_is_run ? 8'd0 : (packet_left - 8'd1);

  assign push                    = accept && pixel_done;
  assign push_entry.word         = word;
  assign push_entry.fmt16        = (pixel_format == tpsd_pkg::FMT_RAW16);
  assign push_entry.repeat_count = rep;
  assign push_entry.last_pixel   = is_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_format <= tpsd_pkg::FORMAT_RESET;
      pixel_total  <= tpsd_pkg::TOTAL_RESET;
    end else if (cfg.valid && cfg.ready) begin
      if (cfg.index == tpsd_pkg::CFG_PIXEL_FORMAT) begin
        pixel_format <= cfg.data[2:0];
      end else if (cfg.index == tpsd_pkg::CFG_PIXEL_TOTAL) begin
        pixel_total <= cfg.data;
      end
    end
  end

  // decoding state
  always_ff @(posedge clk) begin
    if (rst || cfg_write) begin
      byte_phase    <= 2'd0;
      pending_bytes <= 24'd0;
      expect_header <= 1'b1;
      packet_is_run <= 1'b0;
      packet_left   <= 8'd0;
      pixels_left   <= 32'd0;
    end else if (accept) begin
      if (header_byte) begin
        packet_is_run <= b[7];
        packet_left   <= hdr_count_clip;
        expect_header <= 1'b0;
        byte_phase    <= 2'd0;
        pending_bytes <= 24'd0;
        pixels_left   <= pixels_eff;
      end else if (!pixel_done) begin
        case (byte_phase)
          2'd0:    pending_bytes[7:0]   <= b;
          2'd1:    pending_bytes[15:8]  <= b;
          default: pending_bytes[23:16] <= b;
        endcase
        byte_phase  <= byte_phase + 2'd1;
        pixels_left <= pixels_eff;
      end else if (is_last) begin
        byte_phase    <= 2'd0;
        pending_bytes <= 24'd0;
        expect_header <= 1'b1;
        packet_is_run <= 1'b0;
        packet_left   <= 8'd0;
        pixels_left   <= 32'd0;
      end else begin
        byte_phase    <= 2'd0;
        pending_bytes <= 24'd0;
        pixels_left   <= pixels_after;
        if (rle) begin
          packet_left <= packet_left_next;
          if (packet_left_next == 8'd0) begin
            expect_header <= 1'b1;
          end
        end
      end
    end
  end

endmodule

// File: src/tpsd_queue.sv
// tpsd_queue: short fifo of assembled pixels between front and back
// depends on tpsd_pkg
module tpsd_queue (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  push,
  input  tpsd_pkg::tpsd_entry_t push_entry,
  input  logic                  pop,
  output logic                  full,
  output logic                  empty,
  output tpsd_pkg::tpsd_entry_t head
);

  localparam logic [tpsd_pkg::QUEUE_PTR_W-1:0] PTR_LAST =
    tpsd_pkg::QUEUE_PTR_W'(tpsd_pkg::QUEUE_DEPTH - 1);
  localparam logic [tpsd_pkg::QUEUE_PTR_W-1:0] PTR_ONE =
    tpsd_pkg::QUEUE_PTR_W'(1);
  localparam logic [tpsd_pkg::QUEUE_CNT_W-1:0] CNT_FULL =
    tpsd_pkg::QUEUE_CNT_W'(tpsd_pkg::QUEUE_DEPTH);
  localparam logic [tpsd_pkg::QUEUE_CNT_W-1:0] CNT_ONE =
    tpsd_pkg::QUEUE_CNT_W'(1);

  tpsd_pkg::tpsd_entry_t                slots [tpsd_pkg::QUEUE_DEPTH];
  logic [tpsd_pkg::QUEUE_PTR_W-1:0]     wr_ptr;
  logic [tpsd_pkg::QUEUE_PTR_W-1:0]     rd_ptr;
  logic [tpsd_pkg::QUEUE_CNT_W-1:0]     count;
  logic                                 do_push;
  logic                                 do_pop;

  assign full    = (count == CNT_FULL);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  // slot storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + PTR_ONE;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + PTR_ONE;
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_ONE;
      end else if (do_pop && !do_push) begin
        count <= count - CNT_ONE;
      end
    end
  end

endmodule

// File: src/tpsd_back.sv
// tpsd_back: expands queued pixels to rgba and holds the output register
// depends on tpsd_pkg and tpsd_pixel_if
module tpsd_back (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  queue_empty,
  input  tpsd_pkg::tpsd_entry_t head,
  output logic                  pop,
  tpsd_pixel_if.source          pixel_out
);

  logic       out_valid;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic [7:0] repeat_count;
  logic       last_pixel;
  logic [7:0] red_next;
  logic [7:0] green_next;
  logic [7:0] blue_next;
  logic [7:0] alpha_next;

  // take the next entry when the output register is free or being drained
  assign pop = !queue_empty && (!out_valid || pixel_out.ready);

  // colour expansion: 5-5-5 widened by 3, else b,g,r,a byte order
  always_comb begin
    if (head.fmt16) begin
      blue_next  = {head.word[4:0], 3'b000};
      green_next = {head.word[9:5], 3'b000};
      red_next   = {head.word[14:10], 3'b000};
      alpha_next = 8'd0;
    end else begin
      blue_next  = head.word[7:0];
      green_next = head.word[15:8];
      red_next   = head.word[23:16];
      alpha_next = head.word[31:24];
    end
  end

  // output valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (pixel_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      red          <= red_next;
      green        <= green_next;
      blue         <= blue_next;
      alpha        <= alpha_next;
      repeat_count <= head.repeat_count;
      last_pixel   <= head.last_pixel;
    end
  end

  assign pixel_out.valid        = out_valid;
  assign pixel_out.red          = red;
  assign pixel_out.green        = green;
  assign pixel_out.blue         = blue;
  assign pixel_out.alpha        = alpha;
  assign pixel_out.repeat_count = repeat_count;
  assign pixel_out.last_pixel   = last_pixel;

endmodule

// File: src/tga_pixel_stream_decoder.sv
// tga_pixel_stream_decoder: top level of the tga pixel data decoder
// depends on tpsd_pkg, the three channel interfaces, tpsd_front, tpsd_queue, tpsd_back
//
// Decodes the pixel data section of a TGA file, one byte per transfer on
// byte_in, into rgba pixels on pixel_out; rle runs leave as one transfer with
// a repeat count, and the transfer that completes the image has last_pixel set.
// Registers on cfg: index 0 pixel_format (0 raw 16, 1 raw 24, 2 raw 32,
// 3 rle 24, 4 rle 32, others as raw 24), index 1 pixel_total; a write restarts the
// image; the user writes only while the block is idle, the block does not enforce it.
// One byte is taken every cycle as long as the two-entry queue behind the byte front
// end has room; a pixel passes through the queue and then the output register, and
// pixel_out may stall without loss, back-pressuring byte_in once the queue is full.
module tga_pixel_stream_decoder (
  input  logic          clk,
  input  logic          rst,
  tpsd_byte_if.sink     byte_in,
  tpsd_cfg_if.sink      cfg,
  tpsd_pixel_if.source  pixel_out
);

  logic                  push;
  logic                  pop;
  logic                  queue_full;
  logic                  queue_empty;
  tpsd_pkg::tpsd_entry_t push_entry;
  tpsd_pkg::tpsd_entry_t head;

  // byte parsing and pixel assembly
  tpsd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_in    (byte_in),
    .cfg        (cfg),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // pixel queue
  tpsd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .empty      (queue_empty),
    .head       (head)
  );

  // colour expansion and output register
  tpsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (queue_empty),
    .head        (head),
    .pop         (pop),
    .pixel_out   (pixel_out)
  );

endmodule

// File: bench/tb_tga_pixel_stream_decoder.sv
`timescale 1ns / 1ps
// tb_tga_pixel_stream_decoder: self-checking bench for the tga pixel stream decoder
// depends on tpsd_pkg, the byte, cfg and pixel channel interfaces and the top level
module tb_tga_pixel_stream_decoder;

  // format codes outside the defined set, decoded like raw 24-bit
  localparam logic [2:0] FMT_SPARE_LO  = 3'd5;
  localparam logic [2:0] FMT_SPARE_MID = 3'd6;
  localparam logic [2:0] FMT_SPARE_HI  = 3'd7;
  // register index with no register behind it
  localparam logic [tpsd_pkg::CFG_INDEX_W-1:0] CFG_NO_REG = 2'd3;

  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 300;
  localparam int PHASES       = 12;
  localparam int PHASE_BYTES  = 150;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic [7:0] repeat_count;
    logic       last_pixel;
  } pixel_t;

  typedef enum logic {ROW_BYTE, ROW_REG} row_kind_t;

  typedef struct packed {
    row_kind_t                          kind;
    logic [tpsd_pkg::CFG_INDEX_W-1:0]   index;
    logic [31:0]                        value;
    logic                               has_pixel;
    pixel_t                             pixel;
  } row_t;

  localparam pixel_t NO_PIXEL = '0;

  // directed rows: reset state, extremes of the raw 16 and raw 32 formats, clipping, spare codes
  localparam int DIRECTED_ROWS = 31;
  localparam row_t DIRECTED [0:DIRECTED_ROWS-1] = '{
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h11, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h22, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h33, 1'b1,
      '{8'h33, 8'h22, 8'h11, 8'h00, 8'd1, 1'b1}},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_FORMAT, 32'(tpsd_pkg::FMT_RAW16), 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b1,
      '{8'hf8, 8'hf8, 8'hf8, 8'h00, 8'd1, 1'b1}},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h00, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h80, 1'b1,
      '{8'h00, 8'h00, 8'h00, 8'h00, 8'd1, 1'b1}},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_FORMAT, 32'(tpsd_pkg::FMT_RAW32), 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b1,
      '{8'hff, 8'hff, 8'hff, 8'hff, 8'd1, 1'b1}},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_FORMAT, 32'(tpsd_pkg::FMT_RLE32), 1'b0, NO_PIXEL},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_TOTAL, 32'd0, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h01, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h02, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h03, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h04, 1'b1,
      '{8'h03, 8'h02, 8'h01, 8'h04, 8'd1, 1'b1}},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_FORMAT, 32'(tpsd_pkg::FMT_RLE24), 1'b0, NO_PIXEL},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_TOTAL, 32'd5, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h84, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h10, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h20, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h30, 1'b1,
      '{8'h30, 8'h20, 8'h10, 8'h00, 8'd5, 1'b1}},
    '{ROW_REG, tpsd_pkg::CFG_PIXEL_FORMAT, 32'(FMT_SPARE_HI), 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h00, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'h80, 1'b0, NO_PIXEL},
    '{ROW_BYTE, tpsd_pkg::CFG_PIXEL_FORMAT, 32'hff, 1'b0, NO_PIXEL},
    '{ROW_REG, CFG_NO_REG, 32'hffff_ffff, 1'b0, NO_PIXEL}
  };

  // random phases: format, pixel total; idling follows the phase number
  localparam logic [2:0] PHASE_FMT [0:PHASES-1] = '{
    tpsd_pkg::FMT_RAW24, tpsd_pkg::FMT_RAW16, tpsd_pkg::FMT_RAW32,
    tpsd_pkg::FMT_RLE24, tpsd_pkg::FMT_RLE32, tpsd_pkg::FMT_RLE24,
    tpsd_pkg::FMT_RLE32, FMT_SPARE_LO, tpsd_pkg::FMT_RAW16,
    tpsd_pkg::FMT_RLE32, tpsd_pkg::FMT_RLE24, FMT_SPARE_MID
  };
  localparam logic [31:0] PHASE_TOTAL [0:PHASES-1] = '{
    32'd9, 32'd1, 32'd0, 32'd12, 32'd20, 32'hfffe_0001,
    32'd3, 32'd7, 32'hfffe_0001, 32'd40, 32'd2, 32'd11
  };

  logic clk;
  logic rst;

  tpsd_byte_if  byte_in ();
  tpsd_cfg_if   cfg ();
  tpsd_pixel_if pixel_out ();

  tga_pixel_stream_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .byte_in   (byte_in),
    .cfg       (cfg),
    .pixel_out (pixel_out)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // decoder state mirrored by the bench
  logic [2:0]  cur_format;
  logic [31:0] cur_total;
  logic [1:0]  word_pos;
  logic [23:0] held_bytes;
  logic        at_header;
  logic        in_run;
  logic [7:0]  packet_pixels;
  logic [31:0] image_pixels_left;

  pixel_t pixels_due [$];
  int errors = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;

  function automatic void begin_new_image();
    word_pos = '0;
    held_bytes = '0;
    at_header = 1'b1;
    in_run = 1'b0;
    packet_pixels = '0;
    image_pixels_left = '0;
  endfunction

  function automatic int bytes_per_pixel(input logic [2:0] fmt);
    if (fmt == tpsd_pkg::FMT_RAW16) return 2;
    if (fmt == tpsd_pkg::FMT_RAW32 || fmt == tpsd_pkg::FMT_RLE32) return 4;
    return 3;
  endfunction

  // advance the mirrored state by one byte; returns 1 when a pixel or run completes
  function automatic bit decode_byte(input logic [7:0] b, output pixel_t px);
    int bpp;
    bit rle;
    logic [31:0] cnt;
    logic [31:0] w;
    logic [31:0] rep;
    bpp = bytes_per_pixel(cur_format);
    rle = (cur_format == tpsd_pkg::FMT_RLE24) || (cur_format == tpsd_pkg::FMT_RLE32);
    px = '0;
    if (image_pixels_left == 0)
      image_pixels_left = (cur_total == 0) ? 32'd1 : cur_total;

    // packet header: raw count or run count, clipped to the image
    if (rle && at_header) begin
      if (b < 8'd128) begin
        cnt = 32'(b) + 32'd1;
        in_run = 1'b0;
      end else begin
        cnt = 32'(b) - 32'd127;
        in_run = 1'b1;
      end
      if (cnt > image_pixels_left) cnt = image_pixels_left;
      packet_pixels = cnt[7:0];
      at_header = 1'b0;
      word_pos = '0;
      held_bytes = '0;
      return 1'b0;
    end

    // collect the leading bytes of a pixel
    if (int'(word_pos) + 1 < bpp) begin
      held_bytes = held_bytes | (24'(b) << (8 * word_pos));
      word_pos = word_pos + 2'd1;
      return 1'b0;
    end

    w = {8'h00, held_bytes} | (32'(b) << (8 * word_pos));
    word_pos = '0;
    held_bytes = '0;

    // unpack colour, bytes arrive blue first
    if (bpp == 2) begin
      px.blue  = {w[4:0], 3'b000};
      px.green = {w[9:5], 3'b000};
      px.red   = {w[14:10], 3'b000};
    end else begin
      px.blue  = w[7:0];
      px.green = w[15:8];
      px.red   = w[23:16];
      px.alpha = (bpp == 4) ? w[31:24] : 8'h00;
    end

    // repeat count and image bookkeeping
    if (rle) begin
      if (in_run) begin
        rep = 32'(packet_pixels);
        packet_pixels = '0;
      end else begin
        rep = 32'd1;
        packet_pixels = packet_pixels - 8'd1;
      end
      if (packet_pixels == 0) at_header = 1'b1;
    end else begin
      rep = 32'd1;
    end
    if (rep > image_pixels_left) rep = image_pixels_left;
    image_pixels_left = image_pixels_left - rep;
    px.repeat_count = rep[7:0];
    px.last_pixel = (image_pixels_left == 0);
    if (px.last_pixel) begin_new_image();
    return 1'b1;
  endfunction

  function automatic void compare_field(input string name, input logic [7:0] want,
                                        input logic [7:0] seen);
    if (seen !== want) begin
      $error("%s expected %0h actual %0h", name, want, seen);
      errors++;
    end
  endfunction

  // byte transfer; the pixel it completes goes to the expected store
  task automatic send_byte(input logic [7:0] b, input bit has_pixel, input pixel_t pixel);
    pixel_t px;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      byte_in.valid <= 1'b0;
      @(negedge clk);
    end
    byte_in.valid <= 1'b1;
    byte_in.data_byte <= b;
    do @(posedge clk); while (!byte_in.ready);
    if (decode_byte(b, px)) pixels_due.push_back(has_pixel ? pixel : px);
  endtask

  // stop sending and let every expected pixel and any partial work finish
  task automatic drain();
    @(negedge clk);
    byte_in.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [tpsd_pkg::CFG_INDEX_W-1:0] index,
                           input logic [31:0] value);
    drain();
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= value;
    do @(posedge clk); while (!cfg.ready);
    case (index)
      tpsd_pkg::CFG_PIXEL_FORMAT: begin
        cur_format = value[2:0];
        begin_new_image();
      end
      tpsd_pkg::CFG_PIXEL_TOTAL: begin
        cur_total = value;
        begin_new_image();
      end
      default: ;
    endcase
    @(negedge clk);
    cfg.valid <= 1'b0;
    @(posedge clk);
  endtask

  // mostly well-formed packets or pixels with random content, some noise and cut packets
  task automatic send_random_bytes(input int budget);
    int sent;
    int bpp;
    int n;
    int nbytes;
    bit rle;
    logic [7:0] hdr;
    sent = 0;
    bpp = bytes_per_pixel(cur_format);
    rle = (cur_format == tpsd_pkg::FMT_RLE24) || (cur_format == tpsd_pkg::FMT_RLE32);
    while (sent < budget) begin
      if (rle) begin
        if ($urandom_range(99) < 6) begin
          hdr = 8'($urandom_range(255));
        end else begin
          n = ($urandom_range(24) == 0) ? $urandom_range(1, 128) : $urandom_range(1, 6);
          hdr = ($urandom_range(1) != 0) ? 8'(127 + n) : 8'(n - 1);
        end
        send_byte(hdr, 1'b0, NO_PIXEL);
        sent++;
        nbytes = bpp * ((hdr >= 8'd128) ? 1 : int'(hdr) + 1);
        if ($urandom_range(99) < 4) nbytes = $urandom_range(0, nbytes);
      end else begin
        nbytes = ($urandom_range(99) < 3) ? $urandom_range(1, 2 * bpp - 1) : bpp;
      end
      repeat (nbytes) begin
        send_byte(8'($urandom_range(255)), 1'b0, NO_PIXEL);
        sent++;
      end
    end
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin : receiver
    int hold_seen;
    int hold_left;
    hold_seen = 0;
    hold_left = 0;
    pixel_out.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_seen) begin
        hold_seen = hold_req;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        pixel_out.ready <= 1'b0;
      end else begin
        pixel_out.ready <= ($urandom_range(99) >= stall_pct);
      end
    end
  end

  // compare each pixel transfer with the oldest expectation
  always @(posedge clk) begin : pixel_check
    pixel_t want;
    if (!rst && pixel_out.valid && pixel_out.ready) begin
      if (pixels_due.size() == 0) begin
        $error("pixel transfer with none expected: r %0h g %0h b %0h", pixel_out.red,
               pixel_out.green, pixel_out.blue);
        errors++;
      end else begin
        want = pixels_due.pop_front();
        compare_field("red", want.red, pixel_out.red);
        compare_field("green", want.green, pixel_out.green);
        compare_field("blue", want.blue, pixel_out.blue);
        compare_field("alpha", want.alpha, pixel_out.alpha);
        compare_field("repeat_count", want.repeat_count, pixel_out.repeat_count);
        compare_field("last_pixel", 8'(want.last_pixel), 8'(pixel_out.last_pixel));
      end
    end
  end

  initial begin : stimulus
    row_t row;
    rst = 1'b1;
    byte_in.valid = 1'b0;
    byte_in.data_byte = '0;
    cfg.valid = 1'b0;
    cfg.index = tpsd_pkg::CFG_PIXEL_FORMAT;
    cfg.data = '0;
    cur_format = tpsd_pkg::FORMAT_RESET;
    cur_total = tpsd_pkg::TOTAL_RESET;
    begin_new_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // directed table
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      row = DIRECTED[i];
      if (row.kind == ROW_REG) write_reg(row.index, row.value);
      else send_byte(row.value[7:0], row.has_pixel, row.pixel);
    end

    // random phases
    for (int p = 0; p < PHASES; p++) begin
      write_reg(tpsd_pkg::CFG_PIXEL_FORMAT, 32'(PHASE_FMT[p]));
      write_reg(tpsd_pkg::CFG_PIXEL_TOTAL, PHASE_TOTAL[p]);
      case (p % 4)
        0: begin
          idle_pct = 0;
          stall_pct = 0;
        end
        1: begin
          idle_pct = 81;
          stall_pct = 0;
        end
        2: begin
          idle_pct = 0;
          stall_pct = 81;
        end
        default: begin
          idle_pct = 38;
          stall_pct = 38;
        end
      endcase
      // long receiver hold-off while bytes keep coming, fills the queue
      if (p == 0 || p == 4) hold_req++;
      send_random_bytes(PHASE_BYTES);
    end

    drain();
    if (errors == 0) begin
      $display("tb_tga_pixel_stream_decoder OK");
    end else begin
      $display("tb_tga_pixel_stream_decoder NOT OK");
    end
    $finish;
  end

  // run limit
  initial begin : watchdog
    #4000000;
    $display("tb_tga_pixel_stream_decoder NOT OK");
    $finish;
  end

endmodule

// File: filelist.f
src/tpsd_pkg.sv
src/tpsd_byte_if.sv
src/tpsd_pixel_if.sv
src/tpsd_cfg_if.sv
src/tpsd_front.sv
src/tpsd_queue.sv
src/tpsd_back.sv
src/tga_pixel_stream_decoder.sv
bench/tb_tga_pixel_stream_decoder.sv
